// ===== rtl/scan_point_filter_average_macros.svh =====
// Assertion helpers for the scan point filter and averager.
`ifndef SCAN_POINT_FILTER_AVERAGE_MACROS_SVH
`define SCAN_POINT_FILTER_AVERAGE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SPFA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/spfa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spfa_pkg
// Constants, register map and the arctangent helper function of the scan point averager.
// ----------------------------------------------------------------------------
package spfa_pkg;

    localparam int MAX_GROUP     = 64;
    localparam int RANGE_BITS    = 20;
    localparam int CORDIC_STEPS  = 24;
    localparam int DIV_STEPS     = 32;
    localparam int FULL_TURN     = 3600000;
    localparam int HALF_TURN     = 1800000;
    localparam int QUARTER       = 900000;
    localparam int THREE_QUARTER = 2700000;
    localparam logic [31:0] KINV_Q32 = 32'd2608131496;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 96;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_MIN_INTENSITY = 3'd0;
    localparam logic [2:0] REG_ANGLE_LOW     = 3'd1;
    localparam logic [2:0] REG_ANGLE_HIGH    = 3'd2;
    localparam logic [2:0] REG_DIST_LOW      = 3'd3;
    localparam logic [2:0] REG_DIST_HIGH     = 3'd4;
    localparam logic [2:0] REG_GROUP_SIZE    = 3'd5;

    // Arctangent of 2^-i in units of 1/2560000 degree.
    function automatic logic signed [31:0] atan_lut(input logic [4:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:  v = 32'sd115200000;
            5'd1:  v = 32'sd68006531;
            5'd2:  v = 32'sd35932783;
            5'd3:  v = 32'sd18240042;
            5'd4:  v = 32'sd9155416;
            5'd5:  v = 32'sd4582171;
            5'd6:  v = 32'sd2291645;
            5'd7:  v = 32'sd1145892;
            5'd8:  v = 32'sd572955;
            5'd9:  v = 32'sd286479;
            5'd10: v = 32'sd143239;
            5'd11: v = 32'sd71620;
            5'd12: v = 32'sd35810;
            5'd13: v = 32'sd17905;
            5'd14: v = 32'sd8952;
            5'd15: v = 32'sd4476;
            5'd16: v = 32'sd2238;
            5'd17: v = 32'sd1119;
            5'd18: v = 32'sd560;
            5'd19: v = 32'sd280;
            5'd20: v = 32'sd140;
            5'd21: v = 32'sd70;
            5'd22: v = 32'sd35;
            5'd23: v = 32'sd17;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/scan_point_filter_average.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_point_filter_average
// Filters laser-scan samples, converts them to x/y with a shared CORDIC and
// averages groups of points with a bit-serial divider.
// ----------------------------------------------------------------------------
// Channel   Direction  Word
// s         in         tuser: first_of_scan; tdata: start, step, range, inten
// m         out        tdata: avg_x, avg_y, avg_angle, avg_distance
// apb       in/out     six configuration registers at 4*i
//
// A sample passes through accept, one prepare step (the KINV multiply and
// angle folding), 24 CORDIC rotations in one shift/add unit, one accumulate.
// A sample that completes a group then passes the divider and an output load.
// Reset is synchronous and resets the sequencer, sums and configuration; no clearing pass.
// A stalled output word holds the sequencer only when the next result is due.
// ----------------------------------------------------------------------------
module scan_point_filter_average (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // [8:0] start_angle_deg, [24:9] angle_step, [44:25] range,
    // [60:45] intensity, [63:61] zero
    input  logic [spfa_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // [0] first_of_scan
    input  logic                                i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [24:0] avg_x, [49:25] avg_y, [71:50] avg_angle, [95:72] avg_distance
    output logic [spfa_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [4:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import spfa_pkg::*;
`include "scan_point_filter_average_macros.svh"

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PREP = 6'b000010,
        S_ROT  = 6'b000100,
        S_ACC  = 6'b001000,
        S_DIV  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [15:0] r_min_int;
    logic [21:0] r_ang_lo, r_ang_hi;
    logic [19:0] r_dist_lo, r_dist_hi;
    logic [6:0]  r_gsize;

    // Scan and group state.
    logic [21:0]        r_beam;
    logic [15:0]        r_step;
    logic [6:0]         r_count;
    logic signed [31:0] r_sum_x, r_sum_y;
    logic [27:0]        r_sum_ang;
    logic [25:0]        r_sum_dist;

    // Current point.
    logic [19:0]        r_d;
    logic [21:0]        r_ang;
    logic               r_pass;
    logic               r_neg;
    logic signed [39:0] r_x, r_y;
    logic signed [31:0] r_z;
    logic [4:0]         r_cnt;

    // Divider lanes: x, y, angle, distance.
    logic [31:0] r_dq [4];
    logic [7:0]  r_dr [4];
    logic [6:0]  r_div;
    logic        r_sx, r_sy;

    logic [OUT_TDATA_W-1:0] r_m_tdata;
    logic                   r_m_tvalid;

    // Input unpacking.
    logic [8:0]  w_deg;
    logic [15:0] w_step_in;
    logic [19:0] w_range;
    logic [15:0] w_inten;
    logic        w_accept;
    logic [8:0]  w_deg_c;
    logic [21:0] w_ang_now;

    assign w_deg     = i_s_tdata[8:0];
    assign w_step_in = i_s_tdata[24:9];
    assign w_range   = i_s_tdata[44:25];
    assign w_inten   = i_s_tdata[60:45];
    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept  = i_s_tvalid && o_s_tready;
    assign w_deg_c   = (w_deg > 9'd360) ? 9'd360 : w_deg;
    assign w_ang_now = i_s_tuser ? (22'(w_deg_c) * 22'd10000) : r_beam;

    // Prepare: initial CORDIC magnitude and folded angle.
    logic [51:0]        w_prod;
    logic [22:0]        w_t1;
    logic signed [23:0] w_t;
    logic               w_negq;
    always_comb begin
        w_prod = {32'd0, r_d} * {20'd0, KINV_Q32};
        w_t1   = ({1'b0, r_ang} >= 23'(FULL_TURN)) ? ({1'b0, r_ang} - 23'(FULL_TURN))
                                                 : {1'b0, r_ang};
        w_negq = 1'b0;
        if (w_t1 > 23'(QUARTER) && w_t1 <= 23'(THREE_QUARTER)) begin
            w_t    = $signed({1'b0, w_t1}) - 24'sd1800000;
            w_negq = 1'b1;
        end else if (w_t1 > 23'(THREE_QUARTER)) begin
            w_t = $signed({1'b0, w_t1}) - 24'sd3600000;
        end else begin
            w_t = $signed({1'b0, w_t1});
        end
    end

    // One CORDIC rotation per cycle.
    logic signed [39:0] w_dx, w_dy;
    logic signed [31:0] w_atan;
    assign w_dx   = r_y >>> r_cnt;
    assign w_dy   = r_x >>> r_cnt;
    assign w_atan = atan_lut(r_cnt);

    // Accumulate: sign fix, truncate to 4 fraction bits toward zero.
    logic signed [39:0] w_v, w_mag;
    logic signed [25:0] w_px, w_py, w_m;
    logic signed [39:0] w_vy, w_magy;
    logic signed [25:0] w_my;
    logic [6:0]         w_n, w_cnt1;
    logic signed [31:0] w_sx, w_sy;
    logic [27:0]        w_sa;
    logic [25:0]        w_sd;
    always_comb begin
        w_v   = r_neg ? -r_x : r_x;
        w_mag = (w_v < 0) ? -w_v : w_v;
        w_m   = 26'(w_mag >>> 12);
        w_px  = (w_v < 0) ? -w_m : w_m;
        w_vy  = r_neg ? -r_y : r_y;
        w_magy = (w_vy < 0) ? -w_vy : w_vy;
        w_my  = 26'(w_magy >>> 12);
        w_py  = (w_vy < 0) ? -w_my : w_my;
        w_sx  = r_sum_x + 32'(w_px);
        w_sy  = r_sum_y + 32'(w_py);
        w_sa  = r_sum_ang + 28'(r_ang);
        w_sd  = r_sum_dist + 26'(r_d);
        w_cnt1 = r_count + 7'd1;
        if (r_gsize == 7'd0) begin
            w_n = 7'd1;
        end else if (r_gsize > 7'(MAX_GROUP)) begin
            w_n = 7'(MAX_GROUP);
        end else begin
            w_n = r_gsize;
        end
    end

    // One restoring-division step in each lane.
    logic [7:0]  w_sh   [4];
    logic [7:0]  w_rn   [4];
    logic        w_qb   [4];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_sh[k] = {r_dr[k][6:0], r_dq[k][31]};
            w_qb[k] = (w_sh[k] >= {1'b0, r_div});
            w_rn[k] = w_qb[k] ? (w_sh[k] - {1'b0, r_div}) : w_sh[k];
        end
    end

    // Output word from the quotients.
    logic [31:0] w_qx, w_qy;
    assign w_qx = r_sx ? -r_dq[0] : r_dq[0];
    assign w_qy = r_sy ? -r_dq[1] : r_dq[1];

    // Sequencer and datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_beam     <= '0;
            r_step     <= '0;
            r_count    <= '0;
            r_sum_x    <= '0;
            r_sum_y    <= '0;
            r_sum_ang  <= '0;
            r_sum_dist <= '0;
            r_cnt      <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            // The output load below takes over the valid flag in its own state.
            if (r_m_tvalid && i_m_tready && (r_state != S_OUT)) begin
                r_m_tvalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_s_tuser) begin
                            r_step     <= w_step_in;
                            r_beam     <= w_ang_now + 22'(w_step_in);
                            r_count    <= '0;
                            r_sum_x    <= '0;
                            r_sum_y    <= '0;
                            r_sum_ang  <= '0;
                            r_sum_dist <= '0;
                        end else begin
                            r_beam <= r_beam + 22'(r_step);
                        end
                        r_d    <= w_range;
                        r_ang  <= w_ang_now;
                        r_pass <= (w_inten > r_min_int) && (w_ang_now > r_ang_lo) &&
                                  (w_ang_now < r_ang_hi) && (w_range >= r_dist_lo) &&
                                  (w_range <= r_dist_hi);
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_x     <= r_pass ? $signed({4'd0, w_prod[51:16]}) : 40'sd0;
                    r_y     <= 40'sd0;
                    r_z     <= 32'(w_t) <<< 8;
                    r_neg   <= w_negq;
                    r_cnt   <= '0;
                    r_state <= S_ROT;
                end
                S_ROT: begin
                    if (r_z >= 0) begin
                        r_x <= r_x - w_dx;
                        r_y <= r_y + w_dy;
                        r_z <= r_z - w_atan;
                    end else begin
                        r_x <= r_x + w_dx;
                        r_y <= r_y - w_dy;
                        r_z <= r_z + w_atan;
                    end
                    if (r_cnt == 5'(CORDIC_STEPS - 1)) begin
                        r_state <= S_ACC;
                    end
                    r_cnt <= r_cnt + 5'd1;
                end
                S_ACC: begin
                    if (w_cnt1 >= w_n) begin
                        r_dq[0] <= w_sx[31] ? -w_sx : w_sx;
                        r_dq[1] <= w_sy[31] ? -w_sy : w_sy;
                        r_dq[2] <= 32'(w_sa);
                        r_dq[3] <= 32'({w_sd, 4'd0});
                        for (int k = 0; k < 4; k++) begin
                            r_dr[k] <= '0;
                        end
                        r_sx       <= w_sx[31];
                        r_sy       <= w_sy[31];
                        r_div      <= w_cnt1;
                        r_count    <= '0;
                        r_sum_x    <= '0;
                        r_sum_y    <= '0;
                        r_sum_ang  <= '0;
                        r_sum_dist <= '0;
                        r_cnt      <= '0;
                        r_state    <= S_DIV;
                    end else begin
                        r_count    <= w_cnt1;
                        r_sum_x    <= w_sx;
                        r_sum_y    <= w_sy;
                        r_sum_ang  <= w_sa;
                        r_sum_dist <= w_sd;
                        r_state    <= S_IDLE;
                    end
                end
                S_DIV: begin
                    for (int k = 0; k < 4; k++) begin
                        r_dr[k] <= w_rn[k];
                        r_dq[k] <= {r_dq[k][30:0], w_qb[k]};
                    end
                    if (r_cnt == 5'(DIV_STEPS - 1)) begin
                        r_state <= S_OUT;
                    end
                    r_cnt <= r_cnt + 5'd1;
                end
                S_OUT: begin
                    if (!r_m_tvalid || i_m_tready) begin
                        r_m_tdata  <= {r_dq[3][23:0], r_dq[2][21:0], w_qy[24:0], w_qx[24:0]};
                        r_m_tvalid <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

    // Configuration port.
    logic [2:0] w_reg_idx;
    assign w_reg_idx = paddr[4:2];
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_int <= 16'd1;
            r_ang_lo  <= 22'd0;
            r_ang_hi  <= 22'd1800000;
            r_dist_lo <= 20'd0;
            r_dist_hi <= 20'd100000;
            r_gsize   <= 7'd1;
        end else if (psel && penable && pwrite && pready) begin
            case (w_reg_idx)
                REG_MIN_INTENSITY: r_min_int <= pwdata[15:0];
                REG_ANGLE_LOW:     r_ang_lo  <= pwdata[21:0];
                REG_ANGLE_HIGH:    r_ang_hi  <= pwdata[21:0];
                REG_DIST_LOW:      r_dist_lo <= pwdata[19:0];
                REG_DIST_HIGH:     r_dist_hi <= pwdata[19:0];
                REG_GROUP_SIZE:    r_gsize   <= pwdata[6:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (w_reg_idx)
            REG_MIN_INTENSITY: prdata = {16'd0, r_min_int};
            REG_ANGLE_LOW:     prdata = {10'd0, r_ang_lo};
            REG_ANGLE_HIGH:    prdata = {10'd0, r_ang_hi};
            REG_DIST_LOW:      prdata = {12'd0, r_dist_lo};
            REG_DIST_HIGH:     prdata = {12'd0, r_dist_hi};
            REG_GROUP_SIZE:    prdata = {25'd0, r_gsize};
            default:           prdata = 32'd0;
        endcase
    end

    // Checks on the sequencer.
    `SPFA_ASSERT_NEXT(a_accept_prep, w_accept, r_state == S_PREP, "accepted word did not start")
    `SPFA_ASSERT_NOW(a_count_max, 1'b1, r_count < 7'(MAX_GROUP), "group count out of range")
    `SPFA_ASSERT_NEXT(a_out_hold, (r_state == S_OUT) && r_m_tvalid && !i_m_tready, r_state == S_OUT, "result overwrote a waiting word")

endmodule
